@@ rtl/gwn_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Gregorian week number block: widths, codes, constants and the month table.
package gwn_pkg;

   // Field widths of the request, response and control and status register (CSR) port.
   localparam int YEAR_W      = 14;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int DAYNUM_W    = 22;
   localparam int DIFF_W      = 23;
   localparam int WEEK_W      = 19;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;

   // Width of a day-of-year offset (up to 366).
   localparam int DOY_W = 9;

   // Register indexes of the CSR port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_YEAR  = 2'd0,
      CSR_START_MONTH = 2'd1,
      CSR_START_DAY   = 2'd2
   } csr_index_type;

   typedef logic [YEAR_W-1:0]  year_type;
   typedef logic [MONTH_W-1:0] month_type;
   typedef logic [DAY_W-1:0]   day_type;

   // Calendar limits and register reset values.
   localparam year_type  YEAR_MAX          = 14'd9999;
   localparam year_type  START_YEAR_RESET  = 14'd2025;
   localparam month_type MONTH_MAX         = 4'd12;
   localparam month_type MONTH_FEB         = 4'd2;
   localparam month_type START_MONTH_RESET = 4'd9;
   localparam day_type   START_DAY_RESET   = 5'd7;

   // Days in a common year.
   localparam logic [DOY_W-1:0] DAYS_PER_YEAR = 9'd365;

   // Division by 100 for values below 10000: multiply by 5243, shift right by 19.
   localparam int             RECIP100_W = 13;
   localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
   localparam int             SHIFT100   = 19;
   localparam int             CENT_W     = 7;

   // Division by 7 for values below 2**22: multiply by 4793491, shift right by 25.
   localparam int             RECIP7_W = 23;
   localparam logic [RECIP7_W-1:0] RECIP7 = 23'd4793491;
   localparam int             SHIFT7   = 25;

   // Days of a common year that lie before the first of the month.
   function automatic logic [DOY_W-1:0] days_before_month(input month_type month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

@@ rtl/gwn_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the date request and the week number response.
interface gwn_req_if;
   import gwn_pkg::*;

   logic      valid;
   logic      ready;
   year_type  date_year;
   month_type date_month;
   day_type   date_day;

   modport source (output valid, date_year, date_month, date_day, input ready);
   modport sink (input valid, date_year, date_month, date_day, output ready);
   modport monitor (input valid, ready, date_year, date_month, date_day);
endinterface

interface gwn_rsp_if;
   import gwn_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [DAYNUM_W-1:0]        day_number;
   logic signed [DIFF_W-1:0]   days_from_start;
   logic [WEEK_W-1:0]          week_number;
   logic                       date_invalid;

   modport source (output valid, day_number, days_from_start, week_number, date_invalid,
                   input ready);
   modport sink (input valid, day_number, days_from_start, week_number, date_invalid,
                 output ready);
   modport monitor (input valid, ready, day_number, days_from_start, week_number,
                    date_invalid);
endinterface

@@ rtl/gregorian_week_number.sv @@
`timescale 1ns / 1ps
// Top level: converts a Gregorian date into a day number, a day offset and a week number.
// An accepted beat passes stage registers 1 to 5, then the output register, to the response port.
// Throughput: one beat per cycle; the six register stages advance together and hold on a stall.
// The request side is ready whenever the output register is empty or being drained.
// Synchronous active-high reset empties the pipeline and loads the start date 2025-09-07.
// Each beat carries its own copy of the start date, so a CSR write affects later beats only.
module gregorian_week_number (
   input  logic                            clock,
   input  logic                            reset,
   gwn_req_if.sink                         req_bus,
   gwn_rsp_if.source                       rsp_bus,
   input  logic                            csr_we,
   input  logic [gwn_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gwn_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gwn_pkg::*;

   localparam int NUM_LANES  = 2;
   localparam int LANE_DATE  = 0;
   localparam int LANE_START = 1;

   // Stage 1 per lane: year split into prior years and centuries.
   typedef struct packed {
      year_type               year;
      year_type               prior;
      logic [CENT_W-1:0]      cent_prior;
      logic [CENT_W-1:0]      cent_year;
      month_type              month;
      day_type                day;
   } s1_lane_type;

   // Stage 2 per lane: the three partial sums of the day count.
   typedef struct packed {
      logic [DOY_W-1:0]    day_of_year;
      logic [DAYNUM_W-1:0] year_days;
      logic [11:0]         leap_days;
   } s2_lane_type;

   function automatic s1_lane_type split_year(input year_type y, input month_type m,
                                              input day_type d);
      logic [YEAR_W+RECIP100_W-1:0] prod_prior;
      logic [YEAR_W+RECIP100_W-1:0] prod_year;
      s1_lane_type                  res;
      res.year       = y;
      res.prior      = y - 14'd1;
      prod_prior     = (YEAR_W+RECIP100_W)'(res.prior) * (YEAR_W+RECIP100_W)'(RECIP100);
      prod_year      = (YEAR_W+RECIP100_W)'(y) * (YEAR_W+RECIP100_W)'(RECIP100);
      res.cent_prior = prod_prior[SHIFT100 +: CENT_W];
      res.cent_year  = prod_year[SHIFT100 +: CENT_W];
      res.month      = m;
      res.day        = d;
      return res;
   endfunction

   function automatic s2_lane_type partial_sums(input s1_lane_type a);
      year_type    hundreds;
      logic        leap;
      s2_lane_type res;
      hundreds = YEAR_W'(a.cent_year) * YEAR_W'(100);
      leap     = (a.year[1:0] == 2'b00) && ((a.year != hundreds) || (a.cent_year[1:0] == 2'b00));
      res.day_of_year = days_before_month(a.month) + DOY_W'(a.day)
                        + DOY_W'((a.month > MONTH_FEB) && leap);
      res.year_days   = DAYNUM_W'(a.prior) * DAYNUM_W'(DAYS_PER_YEAR);
      res.leap_days   = 12'(a.prior >> 2) - 12'(a.cent_prior) + 12'(a.cent_prior >> 2);
      return res;
   endfunction

   // Start date registers.
   year_type  start_year_ff;
   month_type start_month_ff;
   day_type   start_day_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_year_ff  <= START_YEAR_RESET;
         start_month_ff <= START_MONTH_RESET;
         start_day_ff   <= START_DAY_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_YEAR:  start_year_ff  <= csr_wdata[YEAR_W-1:0];
            CSR_START_MONTH: start_month_ff <= csr_wdata[MONTH_W-1:0];
            CSR_START_DAY:   start_day_ff   <= csr_wdata[DAY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Whole pipeline moves when the output register is empty or being taken.
   logic advance;
   logic rsp_valid_ff;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Lane inputs: the request date and the clamped start date.
   year_type  lane_year  [NUM_LANES];
   month_type lane_month [NUM_LANES];
   day_type   lane_day   [NUM_LANES];
   logic      invalid_in;

   always_comb begin
      lane_year[LANE_DATE]  = req_bus.date_year;
      lane_month[LANE_DATE] = req_bus.date_month;
      lane_day[LANE_DATE]   = req_bus.date_day;

      if (start_year_ff == '0) begin
         lane_year[LANE_START] = 14'd1;
      end else if (start_year_ff > YEAR_MAX) begin
         lane_year[LANE_START] = YEAR_MAX;
      end else begin
         lane_year[LANE_START] = start_year_ff;
      end
      if (start_month_ff == '0) begin
         lane_month[LANE_START] = 4'd1;
      end else if (start_month_ff > MONTH_MAX) begin
         lane_month[LANE_START] = MONTH_MAX;
      end else begin
         lane_month[LANE_START] = start_month_ff;
      end
      lane_day[LANE_START] = (start_day_ff == '0) ? 5'd1 : start_day_ff;

      invalid_in = (req_bus.date_year == '0) || (req_bus.date_year > YEAR_MAX)
                   || (req_bus.date_month == '0) || (req_bus.date_month > MONTH_MAX)
                   || (req_bus.date_day == '0);
   end

   // Stage valid and invalid-date bits.
   logic [4:0] valid_ff;
   logic [4:0] invalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[3:0], req_bus.valid};
         rsp_valid_ff <= valid_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         invalid_ff <= {invalid_ff[3:0], invalid_in};
      end
   end

   // Stage 1: centuries by reciprocal multiplication.
   s1_lane_type s1_in [NUM_LANES];
   s1_lane_type s1_ff [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         s1_in[l] = split_year(lane_year[l], lane_month[l], lane_day[l]);
      end
   end

   // Stage 2: day of year with leap day, days of prior years, leap corrections.
   s2_lane_type s2_in [NUM_LANES];
   s2_lane_type s2_ff [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         s2_in[l] = partial_sums(s1_ff[l]);
      end
   end

   // Stage 3: total day count.
   logic [DAYNUM_W-1:0] count_in [NUM_LANES];
   logic [DAYNUM_W-1:0] count_ff [NUM_LANES];

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         count_in[l] = DAYNUM_W'(s2_ff[l].day_of_year) + s2_ff[l].year_days
                       + DAYNUM_W'(s2_ff[l].leap_days);
      end
   end

   // Stage 4: signed offset from the start date.
   logic signed [DIFF_W-1:0] diff4_in;
   logic signed [DIFF_W-1:0] diff4_ff;
   logic [DAYNUM_W-1:0]      daynum4_ff;

   assign diff4_in = $signed({1'b0, count_ff[LANE_DATE]}) - $signed({1'b0, count_ff[LANE_START]});

   // Stage 5: whole weeks by reciprocal multiplication.
   logic [DAYNUM_W+RECIP7_W-1:0] week_prod;
   logic [WEEK_W-1:0]            weeks5_in;
   logic [WEEK_W-1:0]            weeks5_ff;
   logic signed [DIFF_W-1:0]     diff5_ff;
   logic [DAYNUM_W-1:0]          daynum5_ff;

   assign week_prod = (DAYNUM_W+RECIP7_W)'(diff4_ff[DAYNUM_W-1:0])
                      * (DAYNUM_W+RECIP7_W)'(RECIP7);
   assign weeks5_in = week_prod[SHIFT7 +: WEEK_W];

   // Output register.
   logic [DAYNUM_W-1:0]      day_number_in;
   logic [DAYNUM_W-1:0]      day_number_ff;
   logic signed [DIFF_W-1:0] days_from_start_in;
   logic signed [DIFF_W-1:0] days_from_start_ff;
   logic [WEEK_W-1:0]        week_number_in;
   logic [WEEK_W-1:0]        week_number_ff;
   logic                     date_invalid_ff;

   always_comb begin
      if (invalid_ff[4]) begin
         day_number_in      = '0;
         days_from_start_in = '0;
         week_number_in     = '0;
      end else begin
         day_number_in      = daynum5_ff;
         days_from_start_in = diff5_ff;
         week_number_in     = diff5_ff[DIFF_W-1] ? '0 : weeks5_ff + WEEK_W'(1);
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            s1_ff[l]    <= s1_in[l];
            s2_ff[l]    <= s2_in[l];
            count_ff[l] <= count_in[l];
         end
         diff4_ff           <= diff4_in;
         daynum4_ff         <= count_ff[LANE_DATE];
         weeks5_ff          <= weeks5_in;
         diff5_ff           <= diff4_ff;
         daynum5_ff         <= daynum4_ff;
         day_number_ff      <= day_number_in;
         days_from_start_ff <= days_from_start_in;
         week_number_ff     <= week_number_in;
         date_invalid_ff    <= invalid_ff[4];
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.day_number      = day_number_ff;
   assign rsp_bus.days_from_start = days_from_start_ff;
   assign rsp_bus.week_number     = week_number_ff;
   assign rsp_bus.date_invalid    = date_invalid_ff;

endmodule

@@ rtl/gwn_checker.sv @@
`timescale 1ns / 1ps
// Port checker for the Gregorian week number block and its bind statement.
module gwn_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [gwn_pkg::DAYNUM_W-1:0]      rsp_day_number,
   input  logic signed [gwn_pkg::DIFF_W-1:0] rsp_days_from_start,
   input  logic [gwn_pkg::WEEK_W-1:0]        rsp_week_number,
   input  logic                              rsp_date_invalid
);
   import gwn_pkg::*;

   // A rejected date reports all counts as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_date_invalid |->
         (rsp_day_number == '0) && (rsp_days_from_start == '0)
         && (rsp_week_number == '0))
      else $error("rejected date with nonzero counts");

   // A valid date counts at least one day.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_invalid |-> (rsp_day_number != '0))
      else $error("valid date with day number zero");

   // Week zero exactly before the start date.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_invalid |->
         (rsp_days_from_start[DIFF_W-1] == (rsp_week_number == '0)))
      else $error("week number disagrees with the sign of the offset");

   // A stalled response beat stays and holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_day_number) && $stable(rsp_days_from_start)
         && $stable(rsp_week_number) && $stable(rsp_date_invalid))
      else $error("stalled response beat changed");

endmodule

bind gregorian_week_number gwn_checker u_gwn_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_day_number      (rsp_bus.day_number),
   .rsp_days_from_start (rsp_bus.days_from_start),
   .rsp_week_number     (rsp_bus.week_number),
   .rsp_date_invalid    (rsp_bus.date_invalid)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the Gregorian week number block: directed dates, then random dates.
module tb;
   import gwn_pkg::*;

   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // One response beat as the block should present it.
   typedef struct packed {
      logic [DAYNUM_W-1:0]      day_number;
      logic signed [DIFF_W-1:0] days_from_start;
      logic [WEEK_W-1:0]        week_number;
      logic                     date_invalid;
   } week_result_type;

   // One row of the directed table; the expected beat is used only when typed is set.
   typedef struct packed {
      year_type        year;
      month_type       month;
      day_type         day;
      logic            typed;
      week_result_type want;
   } date_row_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One random phase: the start date to load and how both sides idle.
   typedef struct packed {
      csr_data_type  year;
      csr_data_type  month;
      csr_data_type  day;
      logic          random_start;
      logic          poke_unused;
      idle_mode_type mode;
   } phase_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 166;
   localparam int DIRECTED_COUNT = 22;

   // Days of a common year before the first of each month, indexed by month.
   localparam int unsigned MONTH_OFFSET [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212,
                                                 243, 273, 304, 334};

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   csr_data_type csr_wdata;

   gwn_req_if req_bus ();
   gwn_rsp_if rsp_bus ();

   gregorian_week_number DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies as the block holds them, before any saturation.
   year_type  cfg_year;
   month_type cfg_month;
   day_type   cfg_day;

   week_result_type week_results_due [$];
   int errors = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked = 0;
   int quiet_cycles = 0;

   // Dates on the edges of the calendar and of the start date, malformed dates, and leap-day cases.
   date_row_type directed_rows [DIRECTED_COUNT] = '{
      '{14'd2025, 4'd9, 5'd7, 1'b1, '{22'd739501, 23'sd0, 19'd1, 1'b0}},
      '{14'd2025, 4'd9, 5'd13, 1'b1, '{22'd739507, 23'sd6, 19'd1, 1'b0}},
      '{14'd2025, 4'd9, 5'd14, 1'b1, '{22'd739508, 23'sd7, 19'd2, 1'b0}},
      '{14'd2025, 4'd9, 5'd6, 1'b1, '{22'd739500, -23'sd1, 19'd0, 1'b0}},
      '{14'd1, 4'd1, 5'd1, 1'b1, '{22'd1, -23'sd739500, 19'd0, 1'b0}},
      '{14'd9999, 4'd12, 5'd31, 1'b1, '{22'd3652059, 23'sd2912558, 19'd416080, 1'b0}},
      '{14'd2025, 4'd0, 5'd10, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd2025, 4'd13, 5'd10, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd2025, 4'd15, 5'd31, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd2025, 4'd6, 5'd0, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd0, 4'd6, 5'd15, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd16383, 4'd6, 5'd15, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd10000, 4'd1, 5'd1, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd9999, 4'd15, 5'd31, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd1, 4'd12, 5'd0, 1'b1, '{22'd0, 23'sd0, 19'd0, 1'b1}},
      '{14'd2024, 4'd2, 5'd29, 1'b0, '0},
      '{14'd2023, 4'd2, 5'd31, 1'b0, '0},
      '{14'd2000, 4'd3, 5'd1, 1'b0, '0},
      '{14'd1900, 4'd3, 5'd1, 1'b0, '0},
      '{14'd2024, 4'd12, 5'd31, 1'b0, '0},
      '{14'd2025, 4'd1, 5'd31, 1'b0, '0},
      '{14'd5000, 4'd6, 5'd15, 1'b0, '0}
   };

   // Start dates and idling for the random phases, extremes and out-of-range values included.
   phase_type phases [PHASE_COUNT] = '{
      '{14'd1, 14'd1, 14'd1, 1'b0, 1'b0, IDLE_NONE},
      '{14'd9999, 14'd12, 14'd31, 1'b0, 1'b0, IDLE_SENDER},
      '{14'd0, 14'd0, 14'd0, 1'b0, 1'b1, IDLE_RECEIVER},
      '{14'd16383, 14'h3FFF, 14'h3FE0, 1'b0, 1'b0, IDLE_BOTH},
      '{14'd2000, 14'd2, 14'd29, 1'b0, 1'b0, IDLE_NONE},
      '{14'd1900, 14'd3, 14'd0, 1'b0, 1'b0, IDLE_SENDER},
      '{14'd0, 14'd0, 14'd0, 1'b1, 1'b1, IDLE_RECEIVER},
      '{14'd2025, 14'd9, 14'd7, 1'b0, 1'b0, IDLE_BOTH}
   };

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic bit leap_year(int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   // Day count since 1 January of year one, which counts as day one.
   function automatic int unsigned days_since_epoch(int unsigned year, int unsigned month,
                                                    int unsigned day);
      int unsigned prior;
      int unsigned count;
      prior = year - 1;
      count = day + MONTH_OFFSET[month];
      if (month > 2 && leap_year(year))
         count++;
      return count + 365 * prior + prior / 4 - prior / 100 + prior / 400;
   endfunction

   // The start date after the block clamps its registers into the calendar.
   function automatic void clamped_start(output int unsigned year, output int unsigned month,
                                         output int unsigned day);
      year  = (cfg_year == 0) ? 1 : ((cfg_year > YEAR_MAX) ? YEAR_MAX : cfg_year);
      month = (cfg_month == 0) ? 1 : ((cfg_month > MONTH_MAX) ? MONTH_MAX : cfg_month);
      day   = (cfg_day == 0) ? 1 : cfg_day;
   endfunction

   // Expected response beat for one date under the current start date.
   function automatic week_result_type date_to_week(year_type year, month_type month,
                                                    day_type day);
      week_result_type result;
      int unsigned start_y, start_m, start_d;
      int unsigned date_count;
      int signed offset;
      result = '0;
      if (year == 0 || year > YEAR_MAX || month == 0 || month > MONTH_MAX || day == 0) begin
         result.date_invalid = 1'b1;
         return result;
      end
      clamped_start(start_y, start_m, start_d);
      date_count = days_since_epoch(year, month, day);
      offset = int'(date_count) - int'(days_since_epoch(start_y, start_m, start_d));
      result.day_number      = date_count[DAYNUM_W-1:0];
      result.days_from_start = offset[DIFF_W-1:0];
      result.week_number     = (offset < 0) ? '0 : WEEK_W'(offset / 7 + 1);
      return result;
   endfunction

   // Random dates: mostly well-formed, some near the start date or the calendar ends,
   // the rest raw noise or dates broken on purpose.
   function automatic void random_date(output year_type year, output month_type month,
                                       output day_type day);
      int unsigned start_y, start_m, start_d;
      int unsigned pick;
      clamped_start(start_y, start_m, start_d);
      pick  = $urandom_range(99);
      year  = year_type'($urandom_range(9999, 1));
      month = month_type'($urandom_range(12, 1));
      day   = day_type'($urandom_range(31, 1));
      if (pick < 8) begin
         year  = year_type'($urandom);
         month = month_type'($urandom);
         day   = day_type'($urandom);
      end else if (pick < 16) begin
         if ($urandom_range(1))
            month = ($urandom_range(3) == 0) ? month_type'(0) : month_type'($urandom_range(15, 13));
         else
            day = '0;
      end else if (pick < 36) begin
         year  = year_type'(start_y);
         month = month_type'(start_m);
         if ($urandom_range(3) == 0 && start_m < MONTH_MAX)
            month = month_type'(start_m + 1);
      end else if (pick < 46) begin
         year = $urandom_range(1) ? year_type'($urandom_range(4, 1))
                                  : year_type'($urandom_range(9999, 9996));
      end
   endfunction

   // Offer one date, with random gaps before it, and book its expected beat once accepted.
   task automatic put_date(input year_type year, input month_type month, input day_type day,
                           input logic typed, input week_result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.date_year  <= year;
      req_bus.date_month <= month;
      req_bus.date_day   <= day;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      week_results_due.push_back(typed ? want : date_to_week(year, month, day));
   endtask

   // Stop offering and let every booked beat come out of the pipeline.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (week_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the three start registers back to back, and optionally the unused index.
   task automatic load_start(input csr_data_type year, input csr_data_type month,
                             input csr_data_type day, input logic poke_unused);
      logic [CSR_INDEX_W-1:0] targets [4];
      csr_data_type values [4];
      int count;
      targets = '{CSR_START_YEAR, CSR_START_MONTH, CSR_START_DAY, CSR_UNUSED};
      values  = '{year, month, day, csr_data_type'($urandom)};
      count   = poke_unused ? 4 : 3;
      for (int i = 0; i < count; i++) begin
         csr_we    <= 1'b1;
         csr_index <= targets[i];
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      cfg_year  = year;
      cfg_month = month[MONTH_W-1:0];
      cfg_day   = day[DAY_W-1:0];
   endtask

   // Response side: random stalls, and a long hold-off whenever the stimulus asks for one.
   initial begin : rsp_ready_driver
      int holds_done;
      holds_done = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted response beat with the oldest expectation, field by field.
   always @(posedge clock) begin : result_checker
      week_result_type got;
      week_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.day_number, rsp_bus.days_from_start, rsp_bus.week_number,
                 rsp_bus.date_invalid};
         if (week_results_due.size() == 0) begin
            $display("%0t: unexpected beat: expected none, actual %p", $time, got);
            errors++;
         end else begin
            want = week_results_due.pop_front();
            if (got.day_number !== want.day_number) begin
               $display("%0t: day_number expected %0d, actual %0d", $time,
                        want.day_number, got.day_number);
               errors++;
            end
            if (got.days_from_start !== want.days_from_start) begin
               $display("%0t: days_from_start expected %0d, actual %0d", $time,
                        want.days_from_start, got.days_from_start);
               errors++;
            end
            if (got.week_number !== want.week_number) begin
               $display("%0t: week_number expected %0d, actual %0d", $time,
                        want.week_number, got.week_number);
               errors++;
            end
            if (got.date_invalid !== want.date_invalid) begin
               $display("%0t: date_invalid expected %0b, actual %0b", $time,
                        want.date_invalid, got.date_invalid);
               errors++;
            end
         end
      end
   end

   // Watchdog: too many cycles without any accepted beat ends the run.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      year_type  year;
      month_type month;
      day_type   day;
      phase_type plan;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.date_year  <= '0;
      req_bus.date_month <= '0;
      req_bus.date_day   <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_START_YEAR;
      csr_wdata          <= '0;
      cfg_year  = START_YEAR_RESET;
      cfg_month = START_MONTH_RESET;
      cfg_day   = START_DAY_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed dates under the start date left by reset.
      foreach (directed_rows[i])
         put_date(directed_rows[i].year, directed_rows[i].month, directed_rows[i].day,
                  directed_rows[i].typed, directed_rows[i].want);
      drain();

      // Random phases, each with its own start date and idling.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         plan = phases[p];
         case (plan.mode)
            IDLE_NONE: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            IDLE_SENDER: begin
               send_idle_pct = 75;
               rsp_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
               send_idle_pct = 0;
               rsp_stall_pct = 75;
            end
            default: begin
               send_idle_pct = 15;
               rsp_stall_pct = 15;
            end
         endcase
         if (plan.random_start)
            load_start(csr_data_type'($urandom_range(9999, 1)),
                       (csr_data_type'($urandom) & 14'h3FF0)
                       | csr_data_type'($urandom_range(12, 1)),
                       (csr_data_type'($urandom) & 14'h3FE0)
                       | csr_data_type'($urandom_range(31, 1)),
                       plan.poke_unused);
         else
            load_start(plan.year, plan.month, plan.day, plan.poke_unused);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // Back pressure: the response side holds off while dates keep coming.
            if (p == 2 && k == 40)
               holds_asked++;
            // The sender pauses until the pipeline is empty.
            if (p == 3 && k == 80)
               drain();
            random_date(year, month, day);
            put_date(year, month, day, 1'b0, '0);
         end
         drain();
      end

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/gwn_pkg.sv
rtl/gwn_ifs.sv
rtl/gregorian_week_number.sv
rtl/gwn_checker.sv
tb/tb.sv
